### rtl/core/qpr_pkg.sv
// Shared types, constants and index tables for the quaternion product and rotate unit.
// Depends on nothing; used by qpr_ham and quaternion_product_and_rotate.
package qpr_pkg;

    // Function codes of the func field.
    localparam logic FUNC_PRODUCT = 1'b0;
    localparam logic FUNC_ROTATE  = 1'b1;

    // Number format.
    localparam int QPR_FRAC_BITS = 24;
    localparam int QPR_DATA_W    = 32;
    // Operand width inside the Hamilton pipeline: one extra bit holds the
    // negated most negative value of a conjugate.
    localparam int QPR_OP_W      = QPR_DATA_W + 1;

    localparam logic signed [QPR_DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QPR_DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Components are ordered w, x, y, z (index 0 to 3).
    typedef logic [3:0][QPR_OP_W-1:0]   t_quat_op;
    typedef logic [3:0][QPR_DATA_W-1:0] t_quat;

    // Hamilton product: component k is the sum over n of
    // +/- a[HAM_A_SEL[k][n]] * b[HAM_B_SEL[k][n]], negated where HAM_NEG is set.
    localparam logic [1:0] HAM_A_SEL [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };
    localparam logic [1:0] HAM_B_SEL [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };
    localparam logic HAM_NEG [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1}
    };

    // Sideband carried alongside the first product pass.
    typedef struct packed {
        logic  func;
        t_quat left;
    } t_side1;

    // Sideband carried alongside the second product pass.
    typedef struct packed {
        logic  func;
        t_quat res;
        logic  sat;
    } t_side2;

endpackage

### rtl/core/quaternion_product_and_rotate.sv
// Top level of the fixed-point quaternion product and vector rotate unit.
// Depends on qpr_pkg and two instances of qpr_ham.
//
// Usage: one input channel (i_valid / o_ready) carries a beat with func and
// two quaternions in signed Q8.24; one output channel (o_valid / i_ready)
// returns a beat with four components and a saturation flag. A beat moves
// at a rising edge where valid and ready are both high.
// With func = product the result is left * right. With func = rotate the
// right x, y, z form a vector v and the result is the vector part of
// left * (0,v) * conj(left); out_w is zero.
// A beat passes six register stages, two passes through a
// three-stage Hamilton pipeline (multiply, round, sum and clamp). Product
// beats take the same path, so order is kept for mixed streams.
// Throughput is one beat per cycle while the receiver takes results; every
// stage holds its own valid bit, so the unit keeps accepting while a result waits and bubbles are squeezed out.
// When the receiver stalls, beats pile up stage by stage and o_ready falls
// only once the first stage is full and cannot move; nothing is lost.
// Reset clears all valid bits; data registers are not reset.
module quaternion_product_and_rotate #(
    parameter int FRAC_BITS = qpr_pkg::QPR_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic signed [31:0] i_left_w,
    input  logic signed [31:0] i_left_x,
    input  logic signed [31:0] i_left_y,
    input  logic signed [31:0] i_left_z,
    input  logic signed [31:0] i_right_w,
    input  logic signed [31:0] i_right_x,
    input  logic signed [31:0] i_right_y,
    input  logic signed [31:0] i_right_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_w,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_saturated
);
    import qpr_pkg::*;

    localparam int SIDE1_W = $bits(t_side1);
    localparam int SIDE2_W = $bits(t_side2);

    // First pass: left times right, or left times the pure quaternion (0,v).
    t_quat_op w_a1, w_b1;
    t_side1   w_side1_in, w_side1_out;
    t_quat    w_res1;
    logic [3:0] w_sat1;
    logic     w_v1, w_r1;

    always_comb begin
        w_a1[0] = {i_left_w[31], i_left_w};
        w_a1[1] = {i_left_x[31], i_left_x};
        w_a1[2] = {i_left_y[31], i_left_y};
        w_a1[3] = {i_left_z[31], i_left_z};
        w_b1[0] = (i_func == FUNC_ROTATE) ? '0 : {i_right_w[31], i_right_w};
        w_b1[1] = {i_right_x[31], i_right_x};
        w_b1[2] = {i_right_y[31], i_right_y};
        w_b1[3] = {i_right_z[31], i_right_z};
        w_side1_in.func    = i_func;
        w_side1_in.left[0] = i_left_w;
        w_side1_in.left[1] = i_left_x;
        w_side1_in.left[2] = i_left_y;
        w_side1_in.left[3] = i_left_z;
    end

    qpr_ham #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE1_W)
    ) u_pass1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_a     (w_a1),
        .i_b     (w_b1),
        .i_side  (w_side1_in),
        .o_valid (w_v1),
        .i_ready (w_r1),
        .o_res   (w_res1),
        .o_sat   (w_sat1),
        .o_side  (w_side1_out)
    );

    // Second pass: the clamped first result times the conjugate of left.
    // The conjugate is formed at 33 bits so that negating -2^31 stays exact.
    t_quat_op w_a2, w_b2;
    t_side2   w_side2_in, w_side2_out;
    t_quat    w_res2;
    logic [3:0] w_sat2;

    always_comb begin
        logic signed [QPR_OP_W-1:0] lext;
        for (int i = 0; i < 4; i++) begin
            w_a2[i] = {w_res1[i][QPR_DATA_W-1], w_res1[i]};
            lext    = {w_side1_out.left[i][QPR_DATA_W-1], w_side1_out.left[i]};
            w_b2[i] = (i == 0) ? lext : -lext;
        end
        w_side2_in.func = w_side1_out.func;
        w_side2_in.res  = w_res1;
        w_side2_in.sat  = |w_sat1;
    end

    qpr_ham #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE2_W)
    ) u_pass2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_a     (w_a2),
        .i_b     (w_b2),
        .i_side  (w_side2_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_res2),
        .o_sat   (w_sat2),
        .o_side  (w_side2_out)
    );

    // Product beats take the first-pass result carried as sideband. Rotate
    // beats take the second pass; its scalar part and that clamp are dropped.
    always_comb begin
        if (w_side2_out.func == FUNC_ROTATE) begin
            o_out_w     = '0;
            o_out_x     = w_res2[1];
            o_out_y     = w_res2[2];
            o_out_z     = w_res2[3];
            o_saturated = w_side2_out.sat || (|w_sat2[3:1]);
        end else begin
            o_out_w     = w_side2_out.res[0];
            o_out_x     = w_side2_out.res[1];
            o_out_y     = w_side2_out.res[2];
            o_out_z     = w_side2_out.res[3];
            o_saturated = w_side2_out.sat;
        end
    end

endmodule

### rtl/core/qpr_ham.sv
// Three-stage pipelined Hamilton product with rounding and saturation per component.
// Depends on qpr_pkg for operand types, index tables and clamp limits.
module qpr_ham #(
    parameter int FRAC_BITS = qpr_pkg::QPR_FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  qpr_pkg::t_quat_op     i_a,
    input  qpr_pkg::t_quat_op     i_b,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    input  logic                  i_ready,
    output qpr_pkg::t_quat        o_res,
    output logic [3:0]            o_sat,
    output logic [SIDE_W-1:0]     o_side
);
    import qpr_pkg::*;

    localparam int PROD_W = 2 * QPR_OP_W;
    localparam int RND_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = RND_W + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic [2:0] r_v;
    logic [2:0] w_adv;

    logic signed [PROD_W-1:0]     r_prod [4][4];
    logic signed [RND_W-1:0]      r_rnd  [4][4];
    logic signed [QPR_DATA_W-1:0] r_res  [4];
    logic [3:0]                   r_sat;
    logic [SIDE_W-1:0]            r_side0, r_side1, r_side2;

    logic signed [QPR_OP_W-1:0]   w_a [4];
    logic signed [QPR_OP_W-1:0]   w_b [4];
    logic signed [QPR_DATA_W-1:0] n_res [4];
    logic [3:0]                   n_sat;

    // A stage moves on when it is empty or its successor moves on.
    assign w_adv[2] = !r_v[2] || i_ready;
    assign w_adv[1] = !r_v[1] || w_adv[2];
    assign w_adv[0] = !r_v[0] || w_adv[1];
    assign o_ready  = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_a[i] = i_a[i];
            w_b[i] = i_b[i];
        end
    end

    // Stage 0: sixteen exact products.
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            for (int k = 0; k < 4; k++) begin
                for (int n = 0; n < 4; n++) begin
                    r_prod[k][n] <= w_a[HAM_A_SEL[k][n]] * w_b[HAM_B_SEL[k][n]];
                end
            end
            r_side0 <= i_side;
        end
    end

    // Stage 1: round each product to nearest, halves upward.
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int k = 0; k < 4; k++) begin
                for (int n = 0; n < 4; n++) begin
                    r_rnd[k][n] <= RND_W'((r_prod[k][n] + HALF) >>> FRAC_BITS);
                end
            end
            r_side1 <= r_side0;
        end
    end

    // Stage 2: signed sum of four rounded terms, then clamp to 32 bits.
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic                    ovf_pos;
        logic                    ovf_neg;
        for (int k = 0; k < 4; k++) begin
            sum = '0;
            for (int n = 0; n < 4; n++) begin
                if (HAM_NEG[k][n]) begin
                    sum = sum - SUM_W'(r_rnd[k][n]);
                end else begin
                    sum = sum + SUM_W'(r_rnd[k][n]);
                end
            end
            ovf_pos = !sum[SUM_W-1] && (|sum[SUM_W-2:QPR_DATA_W-1]);
            ovf_neg = sum[SUM_W-1] && !(&sum[SUM_W-2:QPR_DATA_W-1]);
            n_sat[k] = ovf_pos || ovf_neg;
            if (ovf_pos) begin
                n_res[k] = Q_MAX;
            end else if (ovf_neg) begin
                n_res[k] = Q_MIN;
            end else begin
                n_res[k] = sum[QPR_DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int k = 0; k < 4; k++) begin
                r_res[k] <= n_res[k];
            end
            r_sat   <= n_sat;
            r_side2 <= r_side1;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_res[k] = r_res[k];
        end
    end
    assign o_valid = r_v[2];
    assign o_sat   = r_sat;
    assign o_side  = r_side2;

    // Ready drops only when the first stage holds a beat that cannot move.
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v[0])
        else $error("input ready low with an empty first stage");

    // A clamped x component (index 1) carries one of the two limits.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && r_sat[1]) |-> (r_res[1] == Q_MAX || r_res[1] == Q_MIN))
        else $error("saturation flag set on an unclamped component");

    // A stalled output beat keeps its saturation flags and sideband.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && !i_ready) |=> (r_v[2] && $stable(r_sat) && $stable(r_side2)))
        else $error("stalled output beat changed");

    // A middle beat that sits behind a stalled output beat is held.
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && r_v[2] && !i_ready) |=> (r_v[1] && $stable(r_side1)))
        else $error("middle stage lost a beat under stall");

endmodule
